@@ sv/cts_pkg.sv @@
// shared types, character codes and register indexes for the caseless text search
// used by cts_line_track, cts_cell and caseless_text_search; depends on nothing
package cts_pkg;

  // configuration register indexes
  localparam int REG_INDEX_W = 3;
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LEN  = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_START_POS    = 3'd3;

  localparam int CFG_DATA_W    = 64;
  localparam int PATTERN_BYTES = 16;
  localparam int LENGTH_W      = 5;
  localparam int START_W       = 24;
  localparam int FIELD_W       = 24;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_LF     = 8'h0a;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // per-beat control handed to every stage of the chain
  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

  function automatic logic [7:0] fold_text(input logic [7:0] c);
    logic [7:0] r;
    r = to_lower(c);
    if (r == CHAR_SPACE || r == CHAR_LF || r == CHAR_TAB || r == CHAR_CR) r = CHAR_SPACE;
    return r;
  endfunction

endpackage

@@ sv/cts_line_track.sv @@
// running position, newline count and line start of the text stream
// depends on cts_pkg (cell_ctl_t)
module cts_line_track #(
  parameter int POSITION_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cts_pkg::cell_ctl_t           ctl,
  input  logic                         is_lf,
  output logic [3*POSITION_BITS-1:0]   info
);

  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] line_count;
  logic [POSITION_BITS-1:0] line_begin;

  logic [POSITION_BITS-1:0] base_pos;
  logic [POSITION_BITS-1:0] base_count;
  logic [POSITION_BITS-1:0] base_begin;
  logic [POSITION_BITS-1:0] cur_count;
  logic [POSITION_BITS-1:0] cur_begin;

  always_comb begin
    base_pos   = ctl.restart ? '0 : pos;
    base_count = ctl.restart ? '0 : line_count;
    base_begin = ctl.restart ? '0 : line_begin;
    cur_count  = base_count + POSITION_BITS'(is_lf);
    cur_begin  = is_lf ? base_pos + 1'b1 : base_begin;
  end

  // line info as seen at this byte, the byte itself included
  assign info = {cur_count, cur_begin, base_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      line_count <= '0;
      line_begin <= '0;
    end else if (ctl.shift) begin
      pos        <= base_pos + 1'b1;
      line_count <= cur_count;
      line_begin <= cur_begin;
    end
  end

endmodule

@@ sv/cts_cell.sv @@
// one stage of the match chain: partial match flag and start info of the candidate
// depends on cts_pkg (cell_ctl_t)
module cts_cell #(
  parameter int POSITION_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cts_pkg::cell_ctl_t           ctl,
  input  logic [7:0]                   text_char,
  input  logic [7:0]                   pattern_char,
  input  logic                         prev_match,
  input  logic [3*POSITION_BITS-1:0]   prev_info,
  output logic                         match,
  output logic [3*POSITION_BITS-1:0]   info
);

  logic match_next;

  assign match_next = prev_match && !ctl.restart && (text_char == pattern_char);

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.shift) begin
      match <= match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      info <= prev_info;
    end
  end

endmodule

@@ sv/caseless_text_search.sv @@
// caseless text search: one text byte per cycle, result registered behind the chain
// throughput 1 byte per cycle, set by the match chain that advances one stage a beat
// stalls only while a finished result waits on result_stall
// rst clears the chain, counters and result stage; registers return to length 1, zeros
// depends on cts_pkg, cts_line_track, cts_cell
module caseless_text_search #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  // text stream
  input  logic                               text_valid,
  output logic                               text_stall,
  input  logic [7:0]                         text_byte,
  input  logic                               first_byte,
  input  logic                               last_byte,
  // result stream
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               found,
  output logic [cts_pkg::FIELD_W-1:0]        match_start,
  output logic [cts_pkg::FIELD_W-1:0]        line_start,
  output logic [cts_pkg::FIELD_W-1:0]        lines_before,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cts_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int INFO_W = 3 * POSITION_BITS;
  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int CL_W   = (LEN_W > cts_pkg::LENGTH_W) ? LEN_W : cts_pkg::LENGTH_W;
  localparam int CMP_W  = (POSITION_BITS > cts_pkg::START_W) ? POSITION_BITS
                                                              : cts_pkg::START_W;

  // configuration registers
  logic [cts_pkg::CFG_DATA_W-1:0] pattern_low_bytes;
  logic [cts_pkg::CFG_DATA_W-1:0] pattern_high_bytes;
  logic [cts_pkg::LENGTH_W-1:0]   pattern_length;
  logic [cts_pkg::START_W-1:0]    start_position;
  logic [IDX_W-1:0]               len_sel;
  logic [IDX_W-1:0]               len_sel_next;
  logic [CL_W-1:0]                len_wide;

  // handshake and pipeline control
  logic advance;
  logic accept;
  logic done;
  logic eval_valid;
  logic eval_live;
  logic eval_last;
  logic hit_cond;
  logic res_fire;
  logic res_now;

  // chain
  logic [7:0]               text_char;
  logic [INFO_W-1:0]        track_info;
  cts_pkg::cell_ctl_t       track_ctl;
  cts_pkg::cell_ctl_t       cell_ctl     [PATTERN_MAX];
  logic [7:0]               pattern_char [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]   cell_match;
  logic [PATTERN_MAX-1:0]   cell_prev_match;
  logic [INFO_W-1:0]        cell_info    [PATTERN_MAX];
  logic [INFO_W-1:0]        cell_prev_info [PATTERN_MAX];
  logic [2*cts_pkg::CFG_DATA_W-1:0] pattern_all;

  // candidate selected by the pattern length
  logic [INFO_W-1:0]        sel_info;
  logic [POSITION_BITS-1:0] sel_start;
  logic [POSITION_BITS-1:0] sel_line_start;
  logic [POSITION_BITS-1:0] sel_lines_before;

  // ---------------------------------------------------------------------------
  // register writes, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low_bytes  <= '0;
      pattern_high_bytes <= '0;
      pattern_length     <= cts_pkg::LENGTH_W'(1);
      start_position     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cts_pkg::REG_PATTERN_LOW:  pattern_low_bytes  <= cfg_data;
        cts_pkg::REG_PATTERN_HIGH: pattern_high_bytes <= cfg_data;
        cts_pkg::REG_PATTERN_LEN:  pattern_length     <= cfg_data[cts_pkg::LENGTH_W-1:0];
        cts_pkg::REG_START_POS:    start_position     <= cfg_data[cts_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  // length 0 acts as 1, anything past the chain acts as the full chain;
  // kept as the index of the last stage in use
  always_comb begin
    len_wide = CL_W'(pattern_length);
    if (len_wide == '0) begin
      len_sel_next = '0;
    end else if (len_wide > CL_W'(PATTERN_MAX)) begin
      len_sel_next = IDX_W'(PATTERN_MAX - 1);
    end else begin
      len_sel_next = IDX_W'(len_wide - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_sel <= '0;
    end else begin
      len_sel <= len_sel_next;
    end
  end

  // ---------------------------------------------------------------------------
  // input side: the whole pipe moves unless a result is held at the output
  // ---------------------------------------------------------------------------
  assign advance    = !(result_valid && result_stall);
  assign text_stall = !advance;
  assign accept     = text_valid && advance;

  assign text_char = cts_pkg::fold_text(text_byte);

  assign track_ctl.shift   = accept;
  assign track_ctl.restart = accept && first_byte;

  cts_line_track #(
    .POSITION_BITS (POSITION_BITS)
  ) u_line_track (
    .clk   (clk),
    .rst   (rst),
    .ctl   (track_ctl),
    .is_lf (text_byte == cts_pkg::CHAR_LF),
    .info  (track_info)
  );

  // ---------------------------------------------------------------------------
  // match chain: stage j is set when the text ending at the newest byte matches
  // pattern bytes 0..j; it carries the start position and line info of that
  // candidate, so stage len-1 holds the full answer
  // ---------------------------------------------------------------------------
  assign pattern_all = {pattern_high_bytes, pattern_low_bytes};

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_chain
    if (j < cts_pkg::PATTERN_BYTES) begin : g_pat
      assign pattern_char[j] = cts_pkg::to_lower(pattern_all[8*j +: 8]);
    end else begin : g_pat_zero
      // pattern bytes past the register pair read as zero
      assign pattern_char[j] = '0;
    end

    if (j == 0) begin : g_head
      assign cell_prev_match[j]  = 1'b1;
      assign cell_prev_info[j]   = track_info;
      assign cell_ctl[j].shift   = accept;
      assign cell_ctl[j].restart = 1'b0;
    end else begin : g_body
      // a new search drops every partial candidate older than this byte
      assign cell_prev_match[j]  = cell_match[j-1];
      assign cell_prev_info[j]   = cell_info[j-1];
      assign cell_ctl[j].shift   = accept;
      assign cell_ctl[j].restart = accept && first_byte;
    end

    cts_cell #(
      .POSITION_BITS (POSITION_BITS)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cell_ctl[j]),
      .text_char    (text_char),
      .pattern_char (pattern_char[j]),
      .prev_match   (cell_prev_match[j]),
      .prev_info    (cell_prev_info[j]),
      .match        (cell_match[j]),
      .info         (cell_info[j])
    );
  end

  // ---------------------------------------------------------------------------
  // evaluation stage: the most recently accepted beat is judged against the chain
  // ---------------------------------------------------------------------------
  assign sel_info         = cell_info[len_sel];
  assign sel_start        = sel_info[POSITION_BITS-1:0];
  assign sel_line_start   = sel_info[2*POSITION_BITS-1:POSITION_BITS];
  assign sel_lines_before = sel_info[3*POSITION_BITS-1:2*POSITION_BITS];

  assign hit_cond = cell_match[len_sel] &&
                    (CMP_W'(sel_start) >= CMP_W'(start_position));

  // a result is a hit or, failing that, the end of the document
  assign res_fire = eval_valid && eval_live && (hit_cond || eval_last);
  assign res_now  = advance && res_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_valid <= 1'b0;
      eval_live  <= 1'b0;
      eval_last  <= 1'b0;
      done       <= 1'b0;
    end else if (advance) begin
      eval_valid <= accept;
      // a beat after a reported result is dropped until a new search starts
      eval_live  <= first_byte || !(done || res_now);
      eval_last  <= last_byte;
      if (accept && first_byte) begin
        done <= 1'b0;
      end else begin
        done <= done || res_now;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register, payload held while stalled
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      found <= hit_cond;
      if (hit_cond) begin
        match_start  <= cts_pkg::FIELD_W'(sel_start);
        line_start   <= cts_pkg::FIELD_W'(sel_line_start);
        lines_before <= cts_pkg::FIELD_W'(sel_lines_before);
      end else begin
        match_start  <= '0;
        line_start   <= '0;
        lines_before <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a not-found beat carries all-zero fields
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> match_start == '0 && line_start == '0 && lines_before == '0)
    else $error("not-found result with nonzero fields");

  // a reported result closes the search unless a new one starts on the same edge
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    res_now && !(accept && first_byte) |=> done)
    else $error("search not closed after a result");

  // an item waiting in evaluation is kept while the output is held
  a_eval_hold: assert property (@(posedge clk) disable iff (rst)
    eval_valid && !advance |=> eval_valid && $stable(eval_last) && $stable(eval_live))
    else $error("evaluation item lost during output stall");

  // without a hit, only the final byte of a document makes a result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    advance && !hit_cond && !eval_last |=> !result_valid)
    else $error("result without a hit or end of text");

endmodule

@@ bench/cts_search_checker.sv @@
`timescale 1ns / 100ps
// result checker for the caseless text search: watches the text, result and register channels
// keeps its own copy of the search state and registers; depends on cts_pkg
module cts_search_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  input  logic                            text_stall,
  input  logic [7:0]                      text_byte,
  input  logic                            first_byte,
  input  logic                            last_byte,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic                            found,
  input  logic [cts_pkg::FIELD_W-1:0]     match_start,
  input  logic [cts_pkg::FIELD_W-1:0]     line_start,
  input  logic [cts_pkg::FIELD_W-1:0]     lines_before,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [cts_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              results_due
);

  localparam int WINDOW       = cts_pkg::PATTERN_BYTES;
  localparam int FW           = cts_pkg::FIELD_W;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic          found;
    logic [FW-1:0] match_start;
    logic [FW-1:0] line_start;
    logic [FW-1:0] lines_before;
  } search_result_t;

  search_result_t expected_results[$];
  int mismatches = 0;

  // register copies
  logic [cts_pkg::CFG_DATA_W-1:0] pat_low, pat_high;
  logic [cts_pkg::LENGTH_W-1:0]   pat_length;
  logic [cts_pkg::START_W-1:0]    earliest_start;

  // search state, window entry 0 is the newest byte
  logic [7:0]    window_text [WINDOW];
  logic          window_lf   [WINDOW];
  int            window_count;
  logic [FW-1:0] text_pos;
  logic [FW:0]   retired_line_start;
  logic [FW-1:0] retired_lf_count;
  logic          search_over;

  function automatic logic [7:0] comparable_char(input logic [7:0] c, input logic fold_space);
    logic [7:0] r;
    r = c;
    if (c inside {[cts_pkg::CHAR_UPPER_A:cts_pkg::CHAR_UPPER_Z]}) r = c | cts_pkg::CASE_OFFSET;
    if (fold_space && (r inside {cts_pkg::CHAR_SPACE, cts_pkg::CHAR_TAB, cts_pkg::CHAR_CR,
                                 cts_pkg::CHAR_LF})) r = cts_pkg::CHAR_SPACE;
    return r;
  endfunction

  function automatic int effective_length();
    if (pat_length == 0) return 1;
    if (pat_length > WINDOW) return WINDOW;
    return int'(pat_length);
  endfunction

  function automatic logic [7:0] pattern_byte(input int j);
    if (j < 8) return pat_low[8*j +: 8];
    return pat_high[8*(j-8) +: 8];
  endfunction

  task automatic clear_search();
    for (int i = 0; i < WINDOW; i++) begin
      window_text[i] = '0;
      window_lf[i]   = 1'b0;
    end
    window_count       = 0;
    text_pos           = '0;
    retired_line_start = '0;
    retired_lf_count   = '0;
    search_over        = 1'b0;
  endtask

  task automatic predict_beat(input logic [7:0] c, input logic restart, input logic final_beat);
    int len;
    logic hit;
    logic [FW-1:0] pos, first_pos, lf_total;
    logic [FW:0] line_base;
    search_result_t r;
    if (restart) clear_search();
    if (search_over) return;
    pos = text_pos;
    // oldest entry drops out of the window
    if (window_count >= WINDOW && window_lf[WINDOW-1]) begin
      retired_lf_count++;
      retired_line_start = {1'b0, pos - FW'(WINDOW)} + 1'b1;
    end
    for (int i = WINDOW - 1; i > 0; i--) begin
      window_text[i] = window_text[i-1];
      window_lf[i]   = window_lf[i-1];
    end
    window_text[0] = comparable_char(c, 1'b1);
    window_lf[0]   = (c == cts_pkg::CHAR_LF);
    if (window_count < WINDOW) window_count++;
    len = effective_length();
    text_pos = pos + 1'b1;
    if (window_count >= len) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        if (window_text[len-1-j] != comparable_char(pattern_byte(j), 1'b0)) hit = 1'b0;
      end
      first_pos = pos - FW'(len - 1);
      if (hit && first_pos >= earliest_start) begin
        line_base = retired_line_start;
        lf_total  = retired_lf_count;
        for (int k = window_count - 1; k >= len - 1; k--) begin
          if (window_lf[k]) begin
            lf_total++;
            line_base = {1'b0, pos - FW'(k)} + 1'b1;
          end
        end
        r = {1'b1, first_pos, line_base[FW-1:0], lf_total};
        expected_results.push_back(r);
        search_over = 1'b1;
        return;
      end
    end
    if (final_beat) begin
      expected_results.push_back('0);
      search_over = 1'b1;
    end
  endtask

  task automatic check_result(input search_result_t got);
    search_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result beat with nothing expected: found=%0d start=%0d line_start=%0d line=%0d",
                 got.found, got.match_start, got.line_start, got.lines_before);
      return;
    end
    want = expected_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("result mismatch at %0t: expected found=%0d start=%0d line_start=%0d line=%0d",
                 $realtime, want.found, want.match_start, want.line_start, want.lines_before,
                 "; got found=%0d start=%0d line_start=%0d line=%0d",
                 got.found, got.match_start, got.line_start, got.lines_before);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pat_low        = '0;
      pat_high       = '0;
      pat_length     = cts_pkg::LENGTH_W'(1);
      earliest_start = '0;
      clear_search();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cts_pkg::REG_PATTERN_LOW: begin
            pat_low = cfg_data;
          end
          cts_pkg::REG_PATTERN_HIGH: begin
            pat_high = cfg_data;
          end
          cts_pkg::REG_PATTERN_LEN: begin
            pat_length = cfg_data[cts_pkg::LENGTH_W-1:0];
          end
          cts_pkg::REG_START_POS: begin
            earliest_start = cfg_data[cts_pkg::START_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (text_valid && !text_stall) predict_beat(text_byte, first_byte, last_byte);
      if (result_valid && !result_stall)
        check_result({found, match_start, line_start, lines_before});
    end
    fail_count  <= mismatches;
    results_due <= expected_results.size();
  end

endmodule

@@ bench/caseless_text_search_test.sv @@
`timescale 1ns / 100ps
// top of the caseless text search bench: clock, reset, documents, register settings and verdict
// depends on cts_pkg, caseless_text_search and cts_search_checker
module caseless_text_search_test;

  localparam int ITEM_TARGET   = 800;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PAT_BYTES     = cts_pkg::PATTERN_BYTES;
  localparam int LEN_W         = cts_pkg::LENGTH_W;
  localparam int START_W       = cts_pkg::START_W;
  localparam int DATA_W        = cts_pkg::CFG_DATA_W;
  localparam int INDEX_W       = cts_pkg::REG_INDEX_W;
  // index outside the register map, writes to it must be ignored
  localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           text_valid = 1'b0;
  logic                           text_stall;
  logic [7:0]                     text_byte = '0;
  logic                           first_byte = 1'b0;
  logic                           last_byte = 1'b0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic                           found;
  logic [cts_pkg::FIELD_W-1:0]    match_start, line_start, lines_before;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [INDEX_W-1:0]             cfg_index = '0;
  logic [DATA_W-1:0]              cfg_data = '0;

  int fail_count, results_due;

  // idle percentages for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long hold-off handshake between the stimulus and the receiver process
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_sent = 0;

  // what the stimulus knows of the current settings, used to plant matches
  logic [7:0] pattern_text [PAT_BYTES];
  int pattern_used = 1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  caseless_text_search DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .match_start  (match_start),
    .line_start   (line_start),
    .lines_before (lines_before),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cts_search_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .found        (found),
    .match_start  (match_start),
    .line_start   (line_start),
    .lines_before (lines_before),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_due  (results_due)
  );

  // receiver side: random stall, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      result_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // one text beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [7:0] b, input logic is_first, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    first_byte <= is_first;
    last_byte  <= is_last;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == 0, i == s.len() - 1);
  endtask

  // stop offering bytes until every expected result is out, then let the pipe settle
  task automatic wait_results_drained();
    text_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes never lower and raise it in one step
  task automatic write_register(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_settings(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                                input logic [DATA_W-1:0] len_word,
                                input logic [DATA_W-1:0] start_word);
    logic [LEN_W-1:0] len;
    wait_results_drained();
    write_register(cts_pkg::REG_PATTERN_LOW, lo);
    write_register(cts_pkg::REG_PATTERN_HIGH, hi);
    write_register(cts_pkg::REG_PATTERN_LEN, len_word);
    write_register(cts_pkg::REG_START_POS, start_word);
    cfg_valid <= 1'b0;
    for (int j = 0; j < PAT_BYTES; j++)
      pattern_text[j] = (j < 8) ? lo[8*j +: 8] : hi[8*(j-8) +: 8];
    len = len_word[LEN_W-1:0];
    pattern_used = (len == 0) ? 1 : (len > PAT_BYTES) ? PAT_BYTES : int'(len);
  endtask

  // text filler: a small alphabet with all kinds of whitespace so matches stay likely
  function automatic logic [7:0] background_char();
    case ($urandom_range(19))
      0, 1, 2, 3, 4, 5: return "a";
      6, 7, 8, 9:       return "b";
      10:               return "A";
      11:               return "B";
      12, 13:           return cts_pkg::CHAR_LF;
      14:               return cts_pkg::CHAR_SPACE;
      15:               return cts_pkg::CHAR_TAB;
      16:               return cts_pkg::CHAR_CR;
      17:               return "x";
      default:          return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pattern_char();
    case ($urandom_range(9))
      0, 1:    return "a";
      2:       return "b";
      3:       return "A";
      4:       return "B";
      5:       return cts_pkg::CHAR_SPACE;
      6:       return "x";
      7:       return "X";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // a text byte that should compare equal to pattern byte p: random case, any whitespace
  function automatic logic [7:0] text_variant(input logic [7:0] p);
    logic [7:0] lp;
    lp = (p inside {[cts_pkg::CHAR_UPPER_A:cts_pkg::CHAR_UPPER_Z]}) ? p + cts_pkg::CASE_OFFSET
                                                                     : p;
    if (lp inside {["a":"z"]}) return $urandom_range(1) ? lp - cts_pkg::CASE_OFFSET : lp;
    if (lp == cts_pkg::CHAR_SPACE) begin
      case ($urandom_range(3))
        0:       return cts_pkg::CHAR_SPACE;
        1:       return cts_pkg::CHAR_TAB;
        2:       return cts_pkg::CHAR_CR;
        default: return cts_pkg::CHAR_LF;
      endcase
    end
    return p;
  endfunction

  task automatic random_settings();
    logic [DATA_W-1:0] lo, hi, len_word, start_word;
    for (int j = 0; j < 8; j++) begin
      lo[8*j +: 8] = pattern_char();
      hi[8*j +: 8] = pattern_char();
    end
    if ($urandom_range(7) == 0) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end
    // upper bits of the narrow registers are random and must be dropped
    len_word = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       len_word[LEN_W-1:0] = '0;
      1:       len_word[LEN_W-1:0] = LEN_W'(PAT_BYTES);
      2:       len_word[LEN_W-1:0] = LEN_W'($urandom_range(PAT_BYTES + 1, 31));
      3:       len_word[LEN_W-1:0] = LEN_W'(1);
      default: len_word[LEN_W-1:0] = LEN_W'($urandom_range(2, 8));
    endcase
    start_word = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: start_word[START_W-1:0] = '0;
      5, 6:          start_word[START_W-1:0] = START_W'($urandom_range(25));
      7:             start_word[START_W-1:0] = '1;
      default:       start_word[START_W-1:0] = START_W'($urandom);
    endcase
    write_settings(lo, hi, len_word, start_word);
  endtask

  // one document: filler with the pattern planted most of the time, plus some
  // broken framing (missing first or last flag, restart or early end inside)
  task automatic send_document(input logic pause_inside);
    logic [7:0] doc[$];
    int body_len, at, restart_at, stop_at;
    logic noise, no_first, no_last;
    body_len = pattern_used + $urandom_range(30);
    if ($urandom_range(39) == 0) body_len += 150;
    noise = ($urandom_range(9) == 0);
    for (int i = 0; i < body_len; i++)
      doc.push_back(noise ? 8'($urandom_range(255)) : background_char());
    if (!noise && $urandom_range(9) < 7) begin
      at = $urandom_range(body_len - pattern_used);
      for (int j = 0; j < pattern_used; j++) doc[at + j] = text_variant(pattern_text[j]);
    end
    no_first   = ($urandom_range(19) == 0);
    no_last    = ($urandom_range(19) == 0);
    restart_at = (body_len > 1 && $urandom_range(19) == 0) ? $urandom_range(1, body_len - 1) : -1;
    stop_at    = (body_len > 1 && $urandom_range(19) == 0) ? $urandom_range(body_len - 2) : -1;
    for (int i = 0; i < body_len; i++) begin
      if (pause_inside && i == body_len / 2) wait_results_drained();
      send_beat(doc[i], (i == 0 && !no_first) || i == restart_at,
                (i == body_len - 1 && !no_last) || i == stop_at);
    end
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // first third: sender idles 27 of 100, receiver 66
    send_idle_pct = 27;
    recv_idle_pct <= 66;

    // write to a hole in the register map, nothing should change
    write_register(REG_UNUSED, '1);
    cfg_valid <= 1'b0;

    // reset settings: pattern byte zero, length one, match on a lone zero byte
    send_beat(8'h00, 1'b1, 1'b1);

    // "x Y": case folding, tab standing for a space, match on the second line
    write_settings(64'h0000_0000_0059_2078, '0, 64'd3, 64'd0);
    send_string("A\nX\tyz");
    // byte after the report without a new start is ignored
    send_beat("x", 1'b0, 1'b1);
    // document shorter than the pattern
    send_string("xy");

    // full-length pattern of all-ones bytes
    write_settings('1, '1, 64'(PAT_BYTES), 64'd0);
    for (int i = 0; i < PAT_BYTES; i++)
      send_beat(8'hff, i == 0, i == PAT_BYTES - 1);

    // zero length acts as one, start past every position means not found
    write_settings('0, '0, 64'd0, 64'(24'hff_ffff));
    send_beat(8'h00, 1'b1, 1'b1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= 2 * ITEM_TARGET / 3) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end else if (items_sent >= ITEM_TARGET / 3) begin
        send_idle_pct = 66;
        recv_idle_pct <= 27;
      end
      random_settings();
      // long receiver hold-off while documents keep coming, so the block backs up
      if (phase == 2) hold_requests <= hold_requests + 1;
      for (int d = $urandom_range(3, 8); d > 0; d--) send_document(phase == 5 && d == 1);
      phase++;
    end

    wait_results_drained();
    if (fail_count == 0 && results_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/cts_pkg.sv
sv/cts_line_track.sv
sv/cts_cell.sv
sv/caseless_text_search.sv
bench/cts_search_checker.sv
bench/caseless_text_search_test.sv
